FILE: sv/dss_pkg.sv
// dss_pkg: shared types and constants of the disk seek scheduler
// used by dss_cell and disk_seek_scheduler; no dependencies
`timescale 1ns / 1ps

package dss_pkg;

  localparam int unsigned TRACK_W = 10;
  localparam int unsigned KEY_W   = TRACK_W + 1;
  localparam int unsigned TOTAL_W = 14;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [TRACK_W-1:0] START_RESET = 10'd10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY = 2'd1;

  typedef enum logic [1:0] {
    POL_FCFS  = 2'd0,
    POL_SSTF  = 2'd1,
    POL_SCAN  = 2'd2,
    POL_CSCAN = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_EMIT
  } state_e;

  // values broadcast to every cell
  typedef struct packed {
    logic [TRACK_W-1:0] head;
    logic [TRACK_W-1:0] base;
    policy_e            policy;
    logic               clear;
    logic [TRACK_W-1:0] wr_track;
  } bcast_t;

  // best candidate handed down the row
  typedef struct packed {
    logic               vld;
    logic [KEY_W-1:0]   key;
    logic [TRACK_W-1:0] track;
  } cand_t;

endpackage

FILE: sv/dss_cell.sv
// dss_cell: one queue slot holding a request track and its served mark
// compares its own sort key with the candidate from the previous cell; uses dss_pkg
`timescale 1ns / 1ps

module dss_cell #(
  parameter int unsigned IDX_W = 4,
  parameter int unsigned MY_IDX = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dss_pkg::bcast_t       bc_i,
  input  logic                  wr_i,
  input  logic                  mark_i,
  input  dss_pkg::cand_t        cand_i,
  input  logic [IDX_W-1:0]      cand_idx_i,
  output dss_pkg::cand_t        cand_o,
  output logic [IDX_W-1:0]      cand_idx_o
);

  logic [dss_pkg::TRACK_W-1:0] track_q;
  logic                        occ_q, served_q;
  logic [dss_pkg::TRACK_W-1:0] span;
  logic                        up;
  logic [dss_pkg::KEY_W-1:0]   key;
  logic                        own_vld;
  dss_pkg::cand_t              cand_d, cand_q;
  logic [IDX_W-1:0]            idx_d, idx_q;

  // slot storage
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      track_q <= bc_i.wr_track;
    end
  end

  // occupied and served flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= 1'b0;
      served_q <= 1'b0;
    end else if (bc_i.clear) begin
      occ_q    <= 1'b0;
      served_q <= 1'b0;
    end else begin
      if (wr_i) begin
        occ_q    <= 1'b1;
        served_q <= 1'b0;
      end
      if (mark_i) begin
        served_q <= 1'b1;
      end
    end
  end

  // sort key under the current policy, smaller wins
  always_comb begin
    span = (track_q >= bc_i.head) ? (track_q - bc_i.head) : (bc_i.head - track_q);
    up   = (track_q >= bc_i.base);
    case (bc_i.policy)
      dss_pkg::POL_FCFS:  key = '0;
      dss_pkg::POL_SSTF:  key = {1'b0, span};
      dss_pkg::POL_SCAN:  key = up ? {1'b0, track_q} : {1'b1, ~track_q};
      default:            key = {~up, track_q};
    endcase
    own_vld = occ_q && !served_q;
  end

  // keep the earlier candidate on a tie
  always_comb begin
    cand_d = cand_i;
    idx_d  = cand_idx_i;
    if (own_vld && (!cand_i.vld || key < cand_i.key)) begin
      cand_d.vld   = 1'b1;
      cand_d.key   = key;
      cand_d.track = track_q;
      idx_d        = IDX_W'(MY_IDX);
    end
  end

  // candidate register handed to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
      idx_q  <= '0;
    end else begin
      cand_q <= cand_d;
      idx_q  <= idx_d;
    end
  end

  assign cand_o     = cand_q;
  assign cand_idx_o = idx_q;

endmodule

FILE: sv/disk_seek_scheduler.sv
// disk_seek_scheduler: top level, request loading, cell row and result sequencer
// uses dss_pkg and dss_cell
`timescale 1ns / 1ps
//
//  channel  direction  handshake                  payload
//  in       input      in_valid_i / in_stall_o    track_i, last_i
//  out      output     out_valid_o / out_stall_i  served_track_o, move_distance_o,
//                                                 total_distance_o, overflow_o, final_res_o
//  cfg      input      cfg_we_i                   cfg_idx_i, cfg_data_i
//
//  a request with last opens the service phase
//  for each served result the best candidate walks the row of cells, one cell per
//  cycle, and is then committed into the output register
//  in_stall_o is high during the service phase; out_stall_i holds the output register
//  reset clears the queue and sets start track 10 and policy FCFS

module disk_seek_scheduler #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TRACK_COUNT = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [dss_pkg::TRACK_W-1:0]     track_i,
  input  logic                            last_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [dss_pkg::TRACK_W-1:0]     served_track_o,
  output logic [dss_pkg::TRACK_W-1:0]     move_distance_o,
  output logic [dss_pkg::TOTAL_W-1:0]     total_distance_o,
  output logic                            overflow_o,
  output logic                            final_res_o,
  input  logic                            cfg_we_i,
  input  logic [dss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [dss_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [16:0] TRACK_MAX = 17'(TRACK_COUNT - 1);

  // configuration registers
  logic [dss_pkg::TRACK_W-1:0] start_q;
  dss_pkg::policy_e            policy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q  <= dss_pkg::START_RESET;
      policy_q <= dss_pkg::POL_FCFS;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == dss_pkg::REG_START) begin
        start_q <= cfg_data_i[dss_pkg::TRACK_W-1:0];
      end else if (cfg_idx_i == dss_pkg::REG_POLICY) begin
        policy_q <= dss_pkg::policy_e'(cfg_data_i[1:0]);
      end
    end
  end

  // sequencer state
  dss_pkg::state_e             state_q, state_d;
  logic [CNT_W-1:0]            count_q, count_d;
  logic [CNT_W-1:0]            served_q, served_d;
  logic [IDX_W-1:0]            walk_q, walk_d;
  logic                        drop_q, drop_d;
  logic [dss_pkg::TRACK_W-1:0] head_q, head_d;
  logic [dss_pkg::TOTAL_W-1:0] total_q, total_d;

  logic                        out_vld_q, out_vld_d;
  logic [dss_pkg::TRACK_W-1:0] o_track_q, o_move_q;
  logic [dss_pkg::TOTAL_W-1:0] o_total_q;
  logic                        o_ovf_q, o_fin_q;

  logic                        in_acc, out_free, commit, full, clear, is_final;
  logic [dss_pkg::TRACK_W-1:0] sat_track, eff_head, win_track, move;

  dss_pkg::bcast_t             bc;
  dss_pkg::cand_t              cand [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]            cidx [QUEUE_DEPTH+1];

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_vld_q || !out_stall_i;
  assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign sat_track = ({7'd0, track_i} > TRACK_MAX) ? TRACK_MAX[dss_pkg::TRACK_W-1:0] : track_i;
  assign win_track = cand[QUEUE_DEPTH].track;
  assign is_final  = (served_q + CNT_W'(1)) == count_q;

  // first C-SCAN request below the start measures from track zero
  assign eff_head = (policy_q == dss_pkg::POL_CSCAN && win_track < start_q &&
                     head_q >= start_q) ? '0 : head_q;
  assign move = (win_track >= eff_head) ? (win_track - eff_head) : (eff_head - win_track);

  // next state and sequencing
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    served_d   = served_q;
    walk_d     = walk_q;
    drop_d     = drop_q;
    head_d     = head_q;
    total_d    = total_q;
    commit     = 1'b0;
    clear      = 1'b0;
    in_stall_o = 1'b1;
    unique case (state_q)
      dss_pkg::ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_acc) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (last_i) begin
            state_d  = dss_pkg::ST_SEARCH;
            walk_d   = '0;
            served_d = '0;
            head_d   = start_q;
            total_d  = '0;
          end
        end
      end
      dss_pkg::ST_SEARCH: begin
        walk_d = walk_q + IDX_W'(1);
        if (walk_q == IDX_W'(QUEUE_DEPTH - 1)) begin
          state_d = dss_pkg::ST_EMIT;
        end
      end
      dss_pkg::ST_EMIT: begin
        if (out_free) begin
          commit   = 1'b1;
          served_d = served_q + CNT_W'(1);
          head_d   = win_track;
          total_d  = total_q + dss_pkg::TOTAL_W'(move);
          walk_d   = '0;
          if (is_final) begin
            clear    = 1'b1;
            count_d  = '0;
            served_d = '0;
            drop_d   = 1'b0;
            state_d  = dss_pkg::ST_LOAD;
          end else begin
            state_d = dss_pkg::ST_SEARCH;
          end
        end
      end
      default: state_d = dss_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dss_pkg::ST_LOAD;
      count_q  <= '0;
      served_q <= '0;
      walk_q   <= '0;
      drop_q   <= 1'b0;
      head_q   <= dss_pkg::START_RESET;
      total_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      served_q <= served_d;
      walk_q   <= walk_d;
      drop_q   <= drop_d;
      head_q   <= head_d;
      total_q  <= total_d;
    end
  end

  // output register
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end
    if (commit) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      o_track_q <= win_track;
      o_move_q  <= move;
      o_total_q <= total_d;
      o_ovf_q   <= drop_q;
      o_fin_q   <= is_final;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign served_track_o   = o_track_q;
  assign move_distance_o  = o_move_q;
  assign total_distance_o = o_total_q;
  assign overflow_o       = o_ovf_q;
  assign final_res_o      = o_fin_q;

  // broadcast to the row of cells
  always_comb begin
    bc.head     = head_q;
    bc.base     = start_q;
    bc.policy   = policy_q;
    bc.clear    = clear;
    bc.wr_track = sat_track;
  end

  assign cand[0] = '0;
  assign cidx[0] = '0;

  // row of cells, the best candidate moves one cell per cycle
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    dss_cell #(
      .IDX_W (IDX_W),
      .MY_IDX(g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .bc_i      (bc),
      .wr_i      (in_acc && !full && count_q == CNT_W'(g)),
      .mark_i    (commit && cidx[QUEUE_DEPTH] == IDX_W'(g)),
      .cand_i    (cand[g]),
      .cand_idx_i(cidx[g]),
      .cand_o    (cand[g+1]),
      .cand_idx_o(cidx[g+1])
    );
  end

  // a committed result always has a live winner
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |-> cand[QUEUE_DEPTH].vld)
    else $error("commit without a valid candidate");

  // never serve more requests than were stored
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    served_q <= count_q)
    else $error("served count exceeds request count");

  // the final result empties the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit && is_final) |=> (count_q == '0 && state_q == dss_pkg::ST_LOAD))
    else $error("queue not cleared after final result");

  // no request is taken while the batch is being served
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != dss_pkg::ST_LOAD) |-> in_stall_o)
    else $error("input open during service");

endmodule
